>>> design/assert_macros.svh
// Assertion macros used by the LBP design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on the same cycle as the trigger
`define ASSERT_IMPLY(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed: same-cycle implication");

// condition must hold on the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> design/lbp3_pkg.sv
// Package: widths, register indexes and constants of the 3x3 LBP block
`timescale 1ns / 1ps
`default_nettype none
package lbp3_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int COL_W      = ADDR_W;
  localparam int ROW_W      = 12;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int CFG_DATA_W = 12;
  localparam int PIX_W      = 8;
  localparam int LINE_W     = 2 * PIX_W;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd100;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd100;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MIN    = 11'd3;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MAX    = WIDTH_REG_W'(MAX_WIDTH);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MIN   = 12'd3;

  localparam logic [PIX_W-1:0] NONUNIFORM_CODE = 8'd170;
  localparam logic [3:0]       MAX_CHANGES     = 4'd2;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;
endpackage
`default_nettype wire

>>> design/lbp3_ifs.sv
// Stream interfaces: pixel input channel and pattern code output channel
`timescale 1ns / 1ps
`default_nettype none
interface lbp3_pix_if
  import lbp3_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface lbp3_code_if
  import lbp3_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pattern_code;
  logic             is_uniform;
  logic             last_of_frame;

  modport source (output valid, output pattern_code, output is_uniform,
                  output last_of_frame, input ready);
  modport sink (input valid, input pattern_code, input is_uniform,
                input last_of_frame, output ready);
endinterface
`default_nettype wire

>>> design/lbp3_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module lbp3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> design/local_binary_pattern_3x3.sv
// Each accepted pixel is registered into stage 1 and its result into the output
// register; a stalled output beat holds stage 1 in place.
// Throughput: one pixel per clock while the output is not stalled; the line memory
// does one read and one write per cycle, and a read meeting a same-column write is forwarded.
// Reset: position, pipeline and output valid clear, window clears to zero,
// width and height return to 100; the line memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module local_binary_pattern_3x3
  import lbp3_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lbp3_pix_if.sink                   pix,
  lbp3_code_if.source                code
);
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [WIDTH_REG_W-1:0]  eff_width;
  logic [HEIGHT_REG_W-1:0] eff_height;

  logic [COL_W-1:0] col, col_next, c0;
  logic [ROW_W-1:0] row, row_next, r0;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_px;
  logic [COL_W-1:0] s1_c;
  logic [ROW_W-1:0] s1_r;
  logic             s1_fwd;
  logic             s1_adv;
  logic [LINE_W-1:0] wlast;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line_data;
  logic [PIX_W-1:0]  top, mid;

  logic [PIX_W-1:0] win [6];
  logic [PIX_W-1:0] nb [8];
  logic [7:0]       lbp;
  logic [6:0]       diff;
  logic [3:0]       changes;
  logic             produce;
  logic             in_acc;

  logic             out_valid;
  logic [PIX_W-1:0] out_code;
  logic             out_uni;
  logic             out_last;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < WIDTH_MIN) begin
      eff_width = WIDTH_MIN;
    end else if (image_width > WIDTH_MAX) begin
      eff_width = WIDTH_MAX;
    end else begin
      eff_width = image_width;
    end
    eff_height = (image_height < HEIGHT_MIN) ? HEIGHT_MIN : image_height;
  end

  // input side: position tracking and line memory read
  assign s1_adv   = s1_valid && (!out_valid || code.ready);
  assign pix.ready = !s1_valid || s1_adv;
  assign in_acc   = pix.valid && pix.ready;

  assign c0 = pix.frame_start ? '0 : col;
  assign r0 = pix.frame_start ? '0 : row;

  always_comb begin
    col_next = col;
    row_next = row;
    if (in_acc) begin
      if (({1'b0, c0} + 11'd1) >= eff_width) begin
        col_next = '0;
        row_next = (({1'b0, r0} + 13'd1) >= {1'b0, eff_height}) ? '0 : r0 + 12'd1;
      end else begin
        col_next = c0 + 10'd1;
        row_next = r0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px  <= pix.pixel;
      s1_c   <= c0;
      s1_r   <= r0;
      s1_fwd <= s1_adv && (s1_c == c0);
    end
    if (s1_adv) begin
      wlast <= {mid, s1_px};
    end
  end

  lbp3_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(s1_c),
    .wdata({mid, s1_px}),
    .re   (in_acc),
    .raddr(c0),
    .rdata(ram_rdata)
  );

  // upper row in the high byte, middle row in the low byte
  assign line_data = s1_fwd ? wlast : ram_rdata;
  assign top = line_data[LINE_W-1:PIX_W];
  assign mid = line_data[PIX_W-1:0];

  // pattern computation
  always_comb begin
    nb[0] = win[0];
    nb[1] = win[3];
    nb[2] = top;
    nb[3] = mid;
    nb[4] = s1_px;
    nb[5] = win[5];
    nb[6] = win[2];
    nb[7] = win[1];
    for (int i = 0; i < 8; i++) begin
      lbp[7-i] = nb[i] > win[4];
    end
    diff = lbp[7:1] ^ lbp[6:0];
    changes = '0;
    for (int i = 0; i < 7; i++) begin
      changes = changes + {3'b000, diff[i]};
    end
  end

  assign produce = (s1_r >= 12'd2) && (s1_c >= 10'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= s1_px;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && produce) begin
      out_valid <= 1'b1;
    end else if (code.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && produce) begin
      out_code <= (changes > MAX_CHANGES) ? NONUNIFORM_CODE : lbp;
      out_uni  <= changes <= MAX_CHANGES;
      out_last <= (s1_r == eff_height - 12'd1) &&
                  ({1'b0, s1_c} == eff_width - 11'd1);
    end
  end

  assign code.valid         = out_valid;
  assign code.pattern_code  = out_code;
  assign code.is_uniform    = out_uni;
  assign code.last_of_frame = out_last;

  // line memory output must hold while its item waits in stage 1
  `ASSERT_NEXT(a_ram_hold, clk, rst, s1_valid && !s1_adv, $stable(ram_rdata))
  // a non-uniform beat always carries the replacement code
  `ASSERT_IMPLY(a_nonuni_code, clk, rst, out_valid && !out_uni, out_code == NONUNIFORM_CODE)
  // a frame start places the next pixel at column one
  `ASSERT_NEXT(a_frame_col, clk, rst, in_acc && pix.frame_start, col == 10'd1)
  // forwarding only applies to an item that is held in stage 1
  `ASSERT_NEXT(a_fwd_valid, clk, rst, in_acc && s1_adv && (s1_c == c0), s1_valid && s1_fwd)
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the 3x3 local binary pattern stream block
`timescale 1ns / 1ps
module testbench
  import lbp3_pkg::*;
;
  typedef struct {
    logic [PIX_W-1:0] pattern;
    logic             uniform;
    logic             frame_end;
  } code_beat_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum {MIX_FULL, MIX_NARROW, MIX_EXTREME} pixel_mix_t;

  class pattern_checker;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [PIX_W-1:0]        upper_line [MAX_WIDTH];
    logic [PIX_W-1:0]        middle_line [MAX_WIDTH];
    logic [PIX_W-1:0]        win [6];
    int unsigned             col, row;
    code_beat_t              awaited_codes [$];
    int                      errors, pixels, codes, uniform_codes, frame_ends;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      errors = 0;
      pixels = 0;
      codes = 0;
      uniform_codes = 0;
      frame_ends = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) width_reg = value[WIDTH_REG_W-1:0];
      else height_reg = value[HEIGHT_REG_W-1:0];
    endfunction

    function int pending_count();
      return awaited_codes.size();
    endfunction

    // window: [0..2] = column c-2 rows r-2..r, [3..5] = column c-1
    function void accept_pixel(logic [PIX_W-1:0] px, logic fs);
      int unsigned      ew, eh, slot, flips;
      logic [PIX_W-1:0] top, mid;
      logic [PIX_W-1:0] around [8];
      logic [7:0]       bits;
      code_beat_t       beat;
      ew = (width_reg < WIDTH_MIN) ? WIDTH_MIN :
           (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;
      eh = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
      pixels++;
      if (fs) begin
        col = 0;
        row = 0;
      end
      slot = col % MAX_WIDTH;
      top  = upper_line[slot];
      mid  = middle_line[slot];
      if (row >= 2 && col >= 2) begin
        // clockwise from top left, first neighbour is the MSB
        around = '{win[0], win[3], top, mid, px, win[5], win[2], win[1]};
        flips = 0;
        for (int i = 0; i < 8; i++) bits[7-i] = (around[i] > win[4]);
        for (int i = 0; i < 7; i++) begin
          if (bits[7-i] != bits[6-i]) flips++;
        end
        beat.uniform   = (flips <= MAX_CHANGES);
        beat.pattern   = beat.uniform ? bits : NONUNIFORM_CODE;
        beat.frame_end = (row == eh - 1 && col == ew - 1);
        awaited_codes = {awaited_codes, beat};
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = px;
      upper_line[slot]  = mid;
      middle_line[slot] = px;
      if (col + 1 >= ew) begin
        col = 0;
        row = (row + 1 >= eh) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function void compare_code(logic [PIX_W-1:0] pattern, logic uniform, logic frame_end);
      code_beat_t want;
      if (awaited_codes.size() == 0) begin
        $error("unexpected beat: pattern_code %0d with no code pending", pattern);
        errors++;
        return;
      end
      want = awaited_codes.pop_front();
      codes++;
      if (want.uniform) uniform_codes++;
      if (want.frame_end) frame_ends++;
      if (pattern !== want.pattern) begin
        $error("pattern_code: expected %0d, got %0d", want.pattern, pattern);
        errors++;
      end
      if (uniform !== want.uniform) begin
        $error("is_uniform: expected %0b, got %0b", want.uniform, uniform);
        errors++;
      end
      if (frame_end !== want.frame_end) begin
        $error("last_of_frame: expected %0b, got %0b", want.frame_end, frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lbp3_pix_if  pix_ch ();
  lbp3_code_if code_ch ();

  local_binary_pattern_3x3 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_ch),
    .code      (code_ch)
  );

  pattern_checker tracker = new();

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int hold_request = 0;
  int hold_left    = 0;
  int settings     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("local_binary_pattern_3x3 test failed");
    $finish;
  end

  // output side: random stalls, plus long hold-offs on request
  initial begin
    code_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        code_ch.ready <= 1'b0;
      end else begin
        code_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && code_ch.valid && code_ch.ready)
      tracker.compare_code(code_ch.pattern_code, code_ch.is_uniform, code_ch.last_of_frame);
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    while ($urandom_range(99) < send_gap_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= px;
    pix_ch.frame_start <= fs;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    tracker.accept_pixel(px, fs);
  endtask

  // wait out all pending codes, then the pipeline tail of result-less beats
  task automatic settle();
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_registers(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(REG_IMAGE_WIDTH, w);
    tracker.set_register(REG_IMAGE_HEIGHT, h);
    settings++;
  endtask

  function automatic logic [PIX_W-1:0] next_pixel(pixel_mix_t mix, logic [PIX_W-1:0] base);
    case (mix)
      MIX_NARROW:  return base + PIX_W'($urandom_range(2));
      MIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      default:     return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return CFG_DATA_W'($urandom_range(2));
    if (roll == 1) return CFG_DATA_W'($urandom_range(25, 80));
    return CFG_DATA_W'($urandom_range(3, 24));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return CFG_DATA_W'($urandom_range(2));
    if (roll == 1) return 12'd4095;
    if (roll == 2) return CFG_DATA_W'($urandom_range(11, 40));
    return CFG_DATA_W'($urandom_range(3, 10));
  endfunction

  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input idle_mode_t mode, input int count, input bit restart,
                           input pixel_mix_t mix, input int hold);
    logic [PIX_W-1:0] base;
    logic             fs;
    settle();
    set_registers(w, h);
    send_gap_pct = (mode == IDLE_SENDER) ? 46 : (mode == IDLE_BOTH) ? 33 : 0;
    stall_pct    = (mode == IDLE_RECEIVER) ? 46 : (mode == IDLE_BOTH) ? 33 : 0;
    hold_request = hold;
    base = PIX_W'($urandom_range(253));
    for (int i = 0; i < count; i++) begin
      fs = (i == 0 && restart) || ($urandom_range(199) == 0);
      send_pixel(next_pixel(mix, base), fs);
    end
    pix_ch.valid <= 1'b0;
  endtask

  // three 3x3 frames: all neighbours above, alternating (non-uniform),
  // and a single run with ties against the centre
  task automatic run_directed();
    logic [PIX_W-1:0] dots [29] = '{
      8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
      8'd0,   8'd128,
      8'd200, 8'd100, 8'd200, 8'd100, 8'd100, 8'd100, 8'd200, 8'd100, 8'd200,
      8'd78,  8'd90,  8'd255, 8'd76,  8'd77,  8'd10,  8'd77,  8'd0,   8'd77
    };
    settle();
    set_registers(12'd1, 12'd2);
    for (int i = 0; i < 29; i++) send_pixel(dots[i], (i == 0 || i == 11));
    pix_ch.valid <= 1'b0;
  endtask

  initial begin
    int         phase;
    int         sent;
    int         count;
    int         hold;
    pixel_mix_t mix;
    int unsigned roll;
    logic [CFG_DATA_W-1:0] w, h;

    pix_ch.valid       <= 1'b0;
    pix_ch.pixel       <= '0;
    pix_ch.frame_start <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_IMAGE_WIDTH;
    cfg_data           <= '0;
    rst                <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    // widest rows used below: two full rows fill both line stores
    run_phase(12'd80, 12'd4095, IDLE_NONE, 2 * 80 + 40, 1'b1, MIX_FULL, 0);

    phase = 0;
    sent  = 0;
    while (sent < 840) begin
      roll = $urandom_range(19);
      mix  = (roll < 12) ? MIX_FULL : (roll < 17) ? MIX_NARROW : MIX_EXTREME;
      if (phase % 4 == 2) begin
        w     = CFG_DATA_W'($urandom_range(3, 8));
        h     = CFG_DATA_W'($urandom_range(4, 9));
        count = 140;
        hold  = $urandom_range(60, 100);
      end else begin
        w     = pick_width();
        h     = pick_height();
        count = $urandom_range(60, 140);
        hold  = 0;
      end
      run_phase(w, h, idle_mode_t'(phase % 4), count, 1'($urandom_range(1)), mix, hold);
      sent += count;
      phase++;
    end

    settle();
    $display("swept %0d register settings with %0d pixels in", settings, tracker.pixels);
    $display("checked %0d codes, %0d uniform, %0d frame ends", tracker.codes,
             tracker.uniform_codes, tracker.frame_ends);
    if (tracker.errors == 0 && tracker.pending_count() == 0) begin
      $display("local_binary_pattern_3x3 test passed");
    end else begin
      $display("local_binary_pattern_3x3 test failed");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/lbp3_pkg.sv
design/lbp3_ifs.sv
design/lbp3_ram.sv
design/local_binary_pattern_3x3.sv
dv/testbench.sv
